### src/bf_pkg.sv
package bf_pkg;

    // Frame size limits and the widths that follow from them.
    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 4096;

    localparam int ADDR_W = $clog2(MAX_WIDTH);
    localparam int COL_W  = ADDR_W;
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int EW_W   = $clog2(MAX_WIDTH + 1);
    localparam int EH_W   = $clog2(MAX_HEIGHT + 1);
    localparam int FILL_W = $clog2(MAX_WIDTH + 2);

    // Configuration registers.
    localparam int WIDTH_REG_W  = 12;
    localparam int HEIGHT_REG_W = 13;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 13;
    localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = WIDTH_REG_W'(640);
    localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = HEIGHT_REG_W'(480);
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    // Input commands.
    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    // Pixel data.
    localparam int CH_W   = 8;
    localparam int NUM_CH = 3;
    localparam int PIX_W  = CH_W * NUM_CH;
    localparam int LINE_W = 2 * PIX_W;
    localparam int WIN_N  = 9;
    localparam int SUM_W  = 12;

    // floor(s / 9) = (s * 7282) >> 16 for every nine-tap sum of 8-bit values.
    localparam int RECIP9      = 7282;
    localparam int RECIP_SHIFT = 16;
    localparam int PROD_W      = SUM_W + 13;

    // Output queue.
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int PEND_W     = $clog2(FIFO_DEPTH + 1);

    typedef logic [PIX_W-1:0]  pix_t;
    typedef logic [ADDR_W-1:0] addr_t;

    typedef struct packed {
        logic  valid;
        logic  is_pixel;
        logic  emit;
        logic  interior;
        logic  sel_upper;
        logic  frame_end;
        addr_t addr;
        pix_t  pix;
    } issue_t;

    typedef struct packed {
        logic valid;
        logic frame_end;
        pix_t pix;
    } result_t;

    function automatic logic [EW_W-1:0] eff_width(input logic [WIDTH_REG_W-1:0] v);
        logic [EW_W-1:0] r;
        if (v == '0) begin
            r = EW_W'(1);
        end else if (32'(v) > 32'(MAX_WIDTH)) begin
            r = EW_W'(MAX_WIDTH);
        end else begin
            r = EW_W'(v);
        end
        return r;
    endfunction

    function automatic logic [EH_W-1:0] eff_height(input logic [HEIGHT_REG_W-1:0] v);
        logic [EH_W-1:0] r;
        if (v == '0) begin
            r = EH_W'(1);
        end else if (32'(v) > 32'(MAX_HEIGHT)) begin
            r = EH_W'(MAX_HEIGHT);
        end else begin
            r = EH_W'(v);
        end
        return r;
    endfunction

endpackage

### src/bf_if.sv
interface bf_pix_in_if;
    import bf_pkg::*;

    logic            valid;
    logic            ready;
    logic            cmd;
    logic [CH_W-1:0] in_blue;
    logic [CH_W-1:0] in_green;
    logic [CH_W-1:0] in_red;

    modport source (output valid, output cmd, output in_blue, output in_green,
                    output in_red, input ready);
    modport sink (input valid, input cmd, input in_blue, input in_green,
                  input in_red, output ready);
endinterface

interface bf_pix_out_if;
    import bf_pkg::*;

    logic            valid;
    logic            ready;
    logic [CH_W-1:0] out_blue;
    logic [CH_W-1:0] out_green;
    logic [CH_W-1:0] out_red;
    logic            frame_end;

    modport source (output valid, output out_blue, output out_green, output out_red,
                    output frame_end, input ready);
    modport sink (input valid, input out_blue, input out_green, input out_red,
                  input frame_end, output ready);
endinterface

interface bf_cfg_if;
    import bf_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

### src/bf_ram.sv
module bf_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // A read of the address being written returns the old contents.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### src/bf_ctrl.sv
module bf_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    bf_pix_in_if.sink       pix_in,
    bf_cfg_if.sink          cfg,
    input  logic            out_xfer,
    output bf_pkg::issue_t  issue
);
    import bf_pkg::*;

    typedef struct packed {
        logic             wrap;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } pos_t;

    function automatic pos_t advance(input logic [COL_W-1:0] col,
                                     input logic [ROW_W-1:0] row,
                                     input logic [EW_W-1:0]  w,
                                     input logic [EH_W-1:0]  h);
        pos_t p;
        p.wrap = 1'b0;
        p.row  = row;
        p.col  = COL_W'(32'(col) + 32'd1);
        if (32'(col) + 32'd1 >= 32'(w))
        begin
            p.col = '0;
            if (32'(row) + 32'd1 >= 32'(h))
            begin
                p.row  = '0;
                p.wrap = 1'b1;
            end
            else
            begin
                p.row = ROW_W'(32'(row) + 32'd1);
            end
        end
        return p;
    endfunction

    logic [WIDTH_REG_W-1:0]  width_reg, width_next;
    logic [HEIGHT_REG_W-1:0] height_reg, height_next;
    logic [COL_W-1:0]        in_col_reg, in_col_next;
    logic [ROW_W-1:0]        in_row_reg, in_row_next;
    logic [COL_W-1:0]        out_col_reg, out_col_next;
    logic [ROW_W-1:0]        out_row_reg, out_row_next;
    logic [FILL_W-1:0]       fill_reg, fill_next;
    logic [PEND_W-1:0]       pending_reg, pending_next;

    logic [EW_W-1:0]   w;
    logic [EH_W-1:0]   h;
    logic [FILL_W-1:0] w_plus1;
    logic              full;
    logic              in_xfer;
    logic              is_drain;
    logic              interior_pos;
    pos_t              in_adv;
    pos_t              out_adv;

    assign w        = eff_width(width_reg);
    assign h        = eff_height(height_reg);
    assign w_plus1  = FILL_W'(w) + FILL_W'(1);
    assign full     = fill_reg >= w_plus1;
    assign in_xfer  = pix_in.valid && pix_in.ready;
    assign is_drain = pix_in.cmd == CMD_DRAIN;
    assign in_adv   = advance(in_col_reg, in_row_reg, w, h);
    assign out_adv  = advance(out_col_reg, out_row_reg, w, h);

    assign interior_pos = (out_row_reg != '0) && (32'(out_row_reg) + 32'd1 < 32'(h))
                       && (out_col_reg != '0) && (32'(out_col_reg) + 32'd1 < 32'(w));

    // Credits: every accepted item that yields a result holds a queue slot.
    assign pix_in.ready = 32'(pending_reg) < 32'(FIFO_DEPTH);
    assign cfg.ready    = 1'b1;

    always_comb
    begin
        issue.valid     = in_xfer && (!is_drain || fill_reg != '0);
        issue.is_pixel  = !is_drain;
        issue.emit      = is_drain ? (fill_reg != '0) : full;
        issue.interior  = !is_drain && interior_pos;
        issue.sel_upper = full;
        issue.frame_end = out_adv.wrap;
        issue.addr      = is_drain ? ADDR_W'(out_col_reg) : ADDR_W'(in_col_reg);
        issue.pix       = {pix_in.in_red, pix_in.in_green, pix_in.in_blue};
    end

    always_comb
    begin
        width_next   = width_reg;
        height_next  = height_reg;
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        fill_next    = fill_reg;
        pending_next = pending_reg;

        if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                REG_IMAGE_WIDTH:  width_next  = cfg.data[WIDTH_REG_W-1:0];
                REG_IMAGE_HEIGHT: height_next = cfg.data[HEIGHT_REG_W-1:0];
            endcase
        end

        if (in_xfer)
        begin
            if (!is_drain)
            begin
                in_col_next = in_adv.col;
                in_row_next = in_adv.row;
                if (!full)
                begin
                    fill_next = fill_reg + FILL_W'(1);
                end
                else
                begin
                    out_col_next = out_adv.col;
                    out_row_next = out_adv.row;
                end
            end
            else if (fill_reg != '0)
            begin
                fill_next    = fill_reg - FILL_W'(1);
                out_col_next = out_adv.col;
                out_row_next = out_adv.row;
            end
        end

        if (issue.valid && issue.emit && !out_xfer)
        begin
            pending_next = pending_reg + PEND_W'(1);
        end
        else if (!(issue.valid && issue.emit) && out_xfer)
        begin
            pending_next = pending_reg - PEND_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   <= WIDTH_RESET;
            height_reg  <= HEIGHT_RESET;
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            fill_reg    <= '0;
            pending_reg <= '0;
        end
        else
        begin
            width_reg   <= width_next;
            height_reg  <= height_next;
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
            fill_reg    <= fill_next;
            pending_reg <= pending_next;
        end
    end

    // The credit count can never exceed the queue it guards.
    a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(pending_reg) <= 32'(FIFO_DEPTH))
        else $error("output credit count above queue depth");

    // A pixel only raises fill while the window is not yet primed.
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(fill_reg) <= 32'(MAX_WIDTH) + 32'd1)
        else $error("fill count above one row plus one");

endmodule

### src/bf_datapath.sv
module bf_datapath (
    input  logic            clk,
    input  logic            rst_n,
    input  bf_pkg::issue_t  issue,
    output bf_pkg::result_t result
);
    import bf_pkg::*;

    typedef struct packed {
        logic valid;
        logic interior;
        logic frame_end;
        pix_t pix;
    } s2_t;

    typedef struct packed {
        logic                           valid;
        logic                           interior;
        logic                           frame_end;
        pix_t                           pix;
        logic [NUM_CH-1:0][SUM_W-1:0]   sum;
    } s3_t;

    issue_t            s1_reg;
    logic              hit_reg, hit_next;
    logic [LINE_W-1:0] fwd_reg;
    pix_t              win_reg [WIN_N];
    pix_t              win_next [WIN_N];
    s2_t               s2_reg, s2_next;
    s3_t               s3_reg, s3_next;

    logic [LINE_W-1:0] rd_data;
    logic [LINE_W-1:0] line;
    logic [LINE_W-1:0] wr_data;
    logic              wr_en;
    pix_t              upper_old;
    pix_t              middle_old;

    // Each line entry packs the upper row above the middle row.
    bf_ram #(
        .WIDTH (LINE_W),
        .DEPTH (MAX_WIDTH)
    ) u_lines (
        .clk   (clk),
        .we    (wr_en),
        .waddr (s1_reg.addr),
        .wdata (wr_data),
        .raddr (issue.addr),
        .rdata (rd_data)
    );

    assign line       = hit_reg ? fwd_reg : rd_data;
    assign upper_old  = line[LINE_W-1:PIX_W];
    assign middle_old = line[PIX_W-1:0];
    assign wr_en      = s1_reg.valid && s1_reg.is_pixel;
    assign wr_data    = {middle_old, s1_reg.pix};

    // A read issued in the same cycle as a write to that entry sees stale data,
    // so the written line is registered and substituted for the read data.
    assign hit_next = wr_en && (issue.addr == s1_reg.addr);

    always_comb
    begin
        for (int i = 0; i < WIN_N; i++)
        begin
            win_next[i] = win_reg[i];
        end
        if (wr_en)
        begin
            for (int r = 0; r < 3; r++)
            begin
                win_next[r*3]     = win_reg[r*3 + 1];
                win_next[r*3 + 1] = win_reg[r*3 + 2];
            end
            win_next[2] = upper_old;
            win_next[5] = middle_old;
            win_next[8] = s1_reg.pix;
        end
    end

    always_comb
    begin
        s2_next.valid     = s1_reg.valid && s1_reg.emit;
        s2_next.interior  = s1_reg.interior;
        s2_next.frame_end = s1_reg.frame_end;
        if (s1_reg.is_pixel)
        begin
            // Right column of the old window becomes the center after the shift.
            s2_next.pix = win_reg[5];
        end
        else
        begin
            s2_next.pix = s1_reg.sel_upper ? upper_old : middle_old;
        end
    end

    // The window now holds the neighborhood of the item in this stage.
    always_comb
    begin
        s3_next.valid     = s2_reg.valid;
        s3_next.interior  = s2_reg.interior;
        s3_next.frame_end = s2_reg.frame_end;
        s3_next.pix       = s2_reg.pix;
        for (int ch = 0; ch < NUM_CH; ch++)
        begin
            s3_next.sum[ch] = '0;
            for (int i = 0; i < WIN_N; i++)
            begin
                s3_next.sum[ch] = s3_next.sum[ch] + SUM_W'(win_reg[i][ch*CH_W +: CH_W]);
            end
        end
    end

    always_comb
    begin
        logic [PROD_W-1:0] prod;
        pix_t              mean;
        mean = '0;
        for (int ch = 0; ch < NUM_CH; ch++)
        begin
            prod = PROD_W'(s3_reg.sum[ch]) * PROD_W'(RECIP9);
            mean[ch*CH_W +: CH_W] = prod[RECIP_SHIFT +: CH_W];
        end
        result.valid     = s3_reg.valid;
        result.frame_end = s3_reg.frame_end;
        result.pix       = s3_reg.interior ? mean : s3_reg.pix;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg  <= '0;
            hit_reg <= 1'b0;
            fwd_reg <= '0;
            s2_reg  <= '0;
            s3_reg  <= '0;
            for (int i = 0; i < WIN_N; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else
        begin
            s1_reg  <= issue;
            hit_reg <= hit_next;
            fwd_reg <= wr_data;
            s2_reg  <= s2_next;
            s3_reg  <= s3_next;
            for (int i = 0; i < WIN_N; i++)
            begin
                win_reg[i] <= win_next[i];
            end
        end
    end

    // Every result leaving the pipe was an emitting item two stages earlier.
    a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
        s3_reg.valid |-> $past(s1_reg.valid && s1_reg.emit, 2))
        else $error("result without an emitting item behind it");

endmodule

### src/bf_fifo.sv
module bf_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  bf_pkg::result_t push,
    bf_pix_out_if.source    pix_out
);
    import bf_pkg::*;

    logic [PIX_W:0]       entry_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [PEND_W-1:0]    count_reg, count_next;
    logic                 pop;
    logic [PIX_W:0]       head;

    assign head              = entry_reg[rd_ptr_reg];
    assign pix_out.valid     = count_reg != '0;
    assign pix_out.frame_end = head[PIX_W];
    assign pix_out.out_red   = head[2*CH_W +: CH_W];
    assign pix_out.out_green = head[CH_W +: CH_W];
    assign pix_out.out_blue  = head[0 +: CH_W];
    assign pop               = pix_out.valid && pix_out.ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push.valid)
        begin
            wr_ptr_next = (32'(wr_ptr_reg) == FIFO_DEPTH - 1) ? '0
                                                              : wr_ptr_reg + FIFO_AW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (32'(rd_ptr_reg) == FIFO_DEPTH - 1) ? '0
                                                              : rd_ptr_reg + FIFO_AW'(1);
        end
        if (push.valid && !pop)
        begin
            count_next = count_reg + PEND_W'(1);
        end
        else if (!push.valid && pop)
        begin
            count_next = count_reg - PEND_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            entry_reg[wr_ptr_reg] <= {push.frame_end, push.pix};
        end
    end

    // Input credits must keep a full queue from taking another result.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(count_reg) == FIFO_DEPTH) |-> !push.valid)
        else $error("result written into a full output queue");

endmodule

### src/box_filter_3x3_rgb.sv
// 3x3 mean filter over a raster stream of 8-bit BGR pixels.
// pix_in carries one item per transfer: cmd selects a pixel or a drain request.
// Pixel k of the frame comes out on pix_out when pixel k+W+1 goes in, where W
// is the programmed row width; interior pixels are the per-channel mean of the
// 3x3 neighborhood rounded down, border rows and columns pass through. Each
// drain item releases one held pixel unfiltered, so W+1 drains flush a frame.
// frame_end marks the last pixel of each frame; frames may follow back to back.
// cfg writes image_width (index 0) and image_height (index 1); the user must
// write them only while idle, which the block does not enforce. Throughput is
// one item per clock while pix_in.ready is high. Results pass line buffer
// read, window update, nine-tap sum, divide by nine to an 8-entry output queue.
// Both line buffers share one dual-port memory, read and written once a cycle.
// pix_in.ready drops when eight results are accepted but not yet taken, so a
// stalled receiver holds the input back after at most eight results.
// Reset sets 640x480, clears position, fill and window; the line memory is
// not cleared.
module box_filter_3x3_rgb (
    input  logic         clk,
    input  logic         rst_n,
    bf_pix_in_if.sink    pix_in,
    bf_pix_out_if.source pix_out,
    bf_cfg_if.sink       cfg
);
    import bf_pkg::*;

    issue_t  issue;
    result_t result;
    logic    out_xfer;

    assign out_xfer = pix_out.valid && pix_out.ready;

    bf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .pix_in   (pix_in),
        .cfg      (cfg),
        .out_xfer (out_xfer),
        .issue    (issue)
    );

    bf_datapath u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .issue  (issue),
        .result (result)
    );

    bf_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (result),
        .pix_out (pix_out)
    );

endmodule

### bench/box_filter_3x3_rgb_tb.sv
module box_filter_3x3_rgb_tb;
    import bf_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int RANDOM_ITEMS = 1500;
    localparam int REPORT_LIMIT = 10;
    localparam int PIPE_SETTLE  = 8;

    typedef struct packed {
        pix_t pix;
        logic frame_end;
    } pix_result_t;

    typedef enum logic [1:0] {ROW_ITEM, ROW_REG} row_kind_t;

    // One line of the directed plan: an input item or a register write.
    // For items, sel is the command; for writes, the register index.
    typedef struct packed {
        row_kind_t kind;
        logic      sel;
        pix_t      value;
        logic      typed;
        logic      has_out;
        pix_t      out_pix;
        logic      out_fe;
    } dir_row_t;

    logic clk;
    logic rst_n;

    bf_pix_in_if  pix_in_bus ();
    bf_pix_out_if pix_out_bus ();
    bf_cfg_if     cfg_bus ();

    box_filter_3x3_rgb u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .pix_in  (pix_in_bus),
        .pix_out (pix_out_bus),
        .cfg     (cfg_bus)
    );

    // Shadow copy of the filter state.
    logic [WIDTH_REG_W-1:0]  width_reg  = WIDTH_RESET;
    logic [HEIGHT_REG_W-1:0] height_reg = HEIGHT_RESET;
    pix_t        upper_buf [MAX_WIDTH];
    pix_t        middle_buf [MAX_WIDTH];
    pix_t        win [WIN_N];
    int unsigned in_col, in_row, out_col, out_row, pending;

    pix_result_t expected_pixels [$];
    dir_row_t    directed_rows [$];

    int src_idle_pct;
    int snk_idle_pct;
    int fail_count;
    int results_checked;
    int frame_ends;
    int transfers;
    int useful_items;
    int reg_writes;
    int cycle_count;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic int unsigned active_width();
        if (width_reg == '0) return 1;
        if (32'(width_reg) > 32'(MAX_WIDTH)) return MAX_WIDTH;
        return 32'(width_reg);
    endfunction

    function automatic int unsigned active_height();
        if (height_reg == '0) return 1;
        if (32'(height_reg) > 32'(MAX_HEIGHT)) return MAX_HEIGHT;
        return 32'(height_reg);
    endfunction

    // Moves a raster position on by one; returns 1 when it wraps to the frame start.
    function automatic bit step_pos(inout int unsigned col, inout int unsigned row,
                                    input int unsigned w, input int unsigned h);
        col++;
        if (col >= w)
        begin
            col = 0;
            row++;
            if (row >= h)
            begin
                row = 0;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic bit predict_box_mean(input logic cmd_bit, input pix_t px,
                                            output pix_result_t res);
        int unsigned w, h, ic, oc, sum;
        int          r, i, ch;
        pix_t        out_pix;
        w = active_width();
        h = active_height();
        res = '0;
        out_pix = '0;
        if (cmd_bit == CMD_DRAIN)
        begin
            if (pending == 0) return 1'b0;
            // A drained pixel skips the window and comes straight from the line store.
            oc = out_col % MAX_WIDTH;
            out_pix = (pending >= w + 1) ? upper_buf[oc] : middle_buf[oc];
            pending--;
        end
        else
        begin
            ic = in_col % MAX_WIDTH;
            for (r = 0; r < 3; r++)
            begin
                win[r*3]   = win[r*3+1];
                win[r*3+1] = win[r*3+2];
            end
            win[2] = upper_buf[ic];
            win[5] = middle_buf[ic];
            win[8] = px;
            upper_buf[ic]  = middle_buf[ic];
            middle_buf[ic] = px;
            void'(step_pos(in_col, in_row, w, h));
            if (pending < w + 1)
            begin
                pending++;
                return 1'b0;
            end
            if (out_row >= 1 && out_row + 1 < h && out_col >= 1 && out_col + 1 < w)
            begin
                for (ch = 0; ch < 3; ch++)
                begin
                    sum = 0;
                    for (i = 0; i < WIN_N; i++) sum += 32'(win[i][ch*CH_W +: CH_W]);
                    out_pix[ch*CH_W +: CH_W] = CH_W'(sum / WIN_N);
                end
            end
            else
            begin
                out_pix = win[4];
            end
        end
        res.pix = out_pix;
        res.frame_end = step_pos(out_col, out_row, w, h);
        return 1'b1;
    endfunction

    function automatic dir_row_t plan_row(input row_kind_t kind, input logic sel,
                                          input pix_t value, input logic typed,
                                          input logic has_out, input pix_t out_pix,
                                          input logic out_fe);
        dir_row_t row;
        row.kind = kind;
        row.sel = sel;
        row.value = value;
        row.typed = typed;
        row.has_out = has_out;
        row.out_pix = out_pix;
        row.out_fe = out_fe;
        return row;
    endfunction

    // Ends at the rising edge of the transfer; the next call picks up at the falling edge.
    task automatic send_item(input logic cmd_bit, input pix_t px, output bit produced);
        pix_result_t res;
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct)
        begin
            pix_in_bus.valid = 1'b0;
            @(negedge clk);
        end
        pix_in_bus.valid    = 1'b1;
        pix_in_bus.cmd      = cmd_bit;
        pix_in_bus.in_blue  = px[7:0];
        pix_in_bus.in_green = px[15:8];
        pix_in_bus.in_red   = px[23:16];
        do @(posedge clk); while (!pix_in_bus.ready);
        transfers++;
        produced = predict_box_mean(cmd_bit, px, res);
        if (produced) expected_pixels.push_back(res);
        if (cmd_bit == CMD_PIXEL || produced) useful_items++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_bus.valid = 1'b1;
        cfg_bus.index = idx;
        cfg_bus.data  = val;
        do @(posedge clk); while (!cfg_bus.ready);
        if (idx == REG_IMAGE_WIDTH) width_reg = val[WIDTH_REG_W-1:0];
        else height_reg = val[HEIGHT_REG_W-1:0];
        reg_writes++;
        @(negedge clk);
        cfg_bus.valid = 1'b0;
    endtask

    // A drain into an empty pipe leaves no result behind, so after the last
    // result the pipe still gets its full depth before a register changes.
    task automatic settle();
        @(negedge clk);
        pix_in_bus.valid = 1'b0;
        while (expected_pixels.size() != 0) @(posedge clk);
        repeat (PIPE_SETTLE) @(posedge clk);
    endtask

    always @(negedge clk)
    begin
        pix_out_bus.ready = ($urandom_range(99) >= snk_idle_pct);
    end

    always @(posedge clk)
    begin
        pix_result_t want;
        if (rst_n && pix_out_bus.valid && pix_out_bus.ready)
        begin
            if (pix_out_bus.frame_end === 1'b1) frame_ends++;
            if (expected_pixels.size() == 0)
            begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT)
                    $display("ERROR: result with nothing pending: got %06h end=%0b",
                             {pix_out_bus.out_red, pix_out_bus.out_green,
                              pix_out_bus.out_blue}, pix_out_bus.frame_end);
            end
            else
            begin
                want = expected_pixels.pop_front();
                results_checked++;
                if (pix_out_bus.out_blue !== want.pix[7:0] ||
                    pix_out_bus.out_green !== want.pix[15:8] ||
                    pix_out_bus.out_red !== want.pix[23:16] ||
                    pix_out_bus.frame_end !== want.frame_end)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("ERROR: result %0d expected %06h end=%0b, got %06h end=%0b",
                                 results_checked, want.pix, want.frame_end,
                                 {pix_out_bus.out_red, pix_out_bus.out_green,
                                  pix_out_bus.out_blue}, pix_out_bus.frame_end);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d results outstanding",
                     cycle_count, expected_pixels.size());
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        dir_row_t    row;
        bit          got;
        int unsigned n_px, frame_px, k;
        int          pick;
        logic [2:0]  rb;
        pix_t        px;
        logic [CFG_DATA_W-1:0] val;

        rst_n = 1'b0;
        pix_in_bus.valid    = 1'b0;
        pix_in_bus.cmd      = CMD_PIXEL;
        pix_in_bus.in_blue  = '0;
        pix_in_bus.in_green = '0;
        pix_in_bus.in_red   = '0;
        cfg_bus.valid       = 1'b0;
        cfg_bus.index       = REG_IMAGE_WIDTH;
        cfg_bus.data        = '0;
        src_idle_pct = 38;
        snk_idle_pct = 71;
        for (int j = 0; j < MAX_WIDTH; j++)
        begin
            upper_buf[j]  = '0;
            middle_buf[j] = '0;
        end
        for (int j = 0; j < WIN_N; j++) win[j] = '0;
        in_col = 0;
        in_row = 0;
        out_col = 0;
        out_row = 0;
        pending = 0;

        // Drain right after reset, then 1x1 frames where every pixel ends a frame,
        // then a 3x3 frame with a single interior pixel.
        directed_rows.push_back(plan_row(ROW_ITEM, CMD_DRAIN, '0, 1'b1, 1'b0, '0, 1'b0));
        directed_rows.push_back(plan_row(ROW_REG, REG_IMAGE_WIDTH, '0, 1'b0, 1'b0, '0, 1'b0));
        directed_rows.push_back(plan_row(ROW_REG, REG_IMAGE_HEIGHT, '0, 1'b0, 1'b0, '0, 1'b0));
        directed_rows.push_back(plan_row(ROW_ITEM, CMD_PIXEL, 24'h000000, 1'b1, 1'b0,
                                         '0, 1'b0));
        directed_rows.push_back(plan_row(ROW_ITEM, CMD_PIXEL, 24'hffffff, 1'b1, 1'b0,
                                         '0, 1'b0));
        directed_rows.push_back(plan_row(ROW_ITEM, CMD_PIXEL, 24'h80017f, 1'b1, 1'b1,
                                         24'h000000, 1'b1));
        directed_rows.push_back(plan_row(ROW_ITEM, CMD_PIXEL, 24'h7ffe80, 1'b1, 1'b1,
                                         24'hffffff, 1'b1));
        directed_rows.push_back(plan_row(ROW_ITEM, CMD_DRAIN, 24'hffffff, 1'b1, 1'b1,
                                         24'h80017f, 1'b1));
        directed_rows.push_back(plan_row(ROW_ITEM, CMD_DRAIN, '0, 1'b1, 1'b1,
                                         24'h7ffe80, 1'b1));
        directed_rows.push_back(plan_row(ROW_ITEM, CMD_DRAIN, '0, 1'b1, 1'b0, '0, 1'b0));
        directed_rows.push_back(plan_row(ROW_REG, REG_IMAGE_WIDTH, 24'd3, 1'b0, 1'b0,
                                         '0, 1'b0));
        directed_rows.push_back(plan_row(ROW_REG, REG_IMAGE_HEIGHT, 24'd3, 1'b0, 1'b0,
                                         '0, 1'b0));
        directed_rows.push_back(plan_row(ROW_ITEM, CMD_PIXEL, 24'hffffff, 1'b0, 1'b0,
                                         '0, 1'b0));
        directed_rows.push_back(plan_row(ROW_ITEM, CMD_PIXEL, 24'hffffff, 1'b0, 1'b0,
                                         '0, 1'b0));
        directed_rows.push_back(plan_row(ROW_ITEM, CMD_PIXEL, 24'h000000, 1'b0, 1'b0,
                                         '0, 1'b0));
        directed_rows.push_back(plan_row(ROW_ITEM, CMD_PIXEL, 24'hffffff, 1'b0, 1'b0,
                                         '0, 1'b0));
        directed_rows.push_back(plan_row(ROW_ITEM, CMD_PIXEL, 24'hfe01ff, 1'b0, 1'b0,
                                         '0, 1'b0));
        directed_rows.push_back(plan_row(ROW_ITEM, CMD_PIXEL, 24'hffffff, 1'b0, 1'b0,
                                         '0, 1'b0));
        directed_rows.push_back(plan_row(ROW_ITEM, CMD_PIXEL, 24'h000000, 1'b0, 1'b0,
                                         '0, 1'b0));
        directed_rows.push_back(plan_row(ROW_ITEM, CMD_PIXEL, 24'hffffff, 1'b0, 1'b0,
                                         '0, 1'b0));
        directed_rows.push_back(plan_row(ROW_ITEM, CMD_PIXEL, 24'h55aa0f, 1'b0, 1'b0,
                                         '0, 1'b0));
        repeat (4)
            directed_rows.push_back(plan_row(ROW_ITEM, CMD_DRAIN, '0, 1'b0, 1'b0,
                                             '0, 1'b0));
        directed_rows.push_back(plan_row(ROW_ITEM, CMD_DRAIN, '0, 1'b1, 1'b0, '0, 1'b0));

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[n])
        begin
            row = directed_rows[n];
            if (row.kind == ROW_REG)
            begin
                settle();
                write_reg(row.sel, row.value[CFG_DATA_W-1:0]);
            end
            else
            begin
                send_item(row.sel, row.value, got);
                if (row.typed)
                begin
                    if (got) void'(expected_pixels.pop_back());
                    if (row.has_out) expected_pixels.push_back({row.out_pix, row.out_fe});
                end
            end
        end

        // Width register above the limit: the row is 2048 wide, so nothing leaves
        // until the drains release the held pixels unfiltered. The short burst
        // leaves the input column below 40.
        settle();
        write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(4095));
        write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(2));
        repeat (38) send_item(CMD_PIXEL, PIX_W'($urandom), got);
        while (pending != 0) send_item(CMD_DRAIN, PIX_W'($urandom), got);
        send_item(CMD_DRAIN, PIX_W'($urandom), got);

        // Two full 40-pixel rows write both halves of every line store entry that
        // the later part can address, so it reads only entries that hold real pixels.
        settle();
        write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(40));
        write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(2));
        repeat (80) send_item(CMD_PIXEL, PIX_W'($urandom), got);
        while (pending != 0) send_item(CMD_DRAIN, PIX_W'($urandom), got);

        // Height register at its top value.
        settle();
        write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(3));
        write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(8191));
        repeat (30) send_item(CMD_PIXEL, PIX_W'($urandom), got);
        while (pending != 0) send_item(CMD_DRAIN, PIX_W'($urandom), got);

        useful_items = 0;
        while (useful_items < RANDOM_ITEMS)
        begin
            if (useful_items >= 2 * RANDOM_ITEMS / 3)
            begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end
            else if (useful_items >= RANDOM_ITEMS / 3)
            begin
                src_idle_pct = 71;
                snk_idle_pct = 38;
            end
            // The previous burst may have stopped mid-frame with pixels held back,
            // so a new size can land in the middle of a frame.
            settle();
            pick = $urandom_range(9);
            if (pick != 1)
            begin
                k = $urandom_range(99);
                if (k < 5) val = '0;
                else if (k < 85) val = CFG_DATA_W'($urandom_range(1, 8));
                else val = CFG_DATA_W'($urandom_range(9, 40));
                write_reg(REG_IMAGE_WIDTH, val);
            end
            if (pick != 0)
            begin
                k = $urandom_range(99);
                if (k < 5) val = '0;
                else if (k < 85) val = CFG_DATA_W'($urandom_range(1, 6));
                else val = CFG_DATA_W'($urandom_range(0, 8191));
                write_reg(REG_IMAGE_HEIGHT, val);
            end

            frame_px = active_width() * active_height();
            if (frame_px <= 150 && $urandom_range(99) < 65)
                n_px = frame_px * $urandom_range(1, 3);
            else
                n_px = $urandom_range(1, 150);

            repeat (n_px)
            begin
                if ($urandom_range(99) < 6) send_item(CMD_DRAIN, PIX_W'($urandom), got);
                if ($urandom_range(9) == 0)
                begin
                    rb = 3'($urandom);
                    px = {{CH_W{rb[2]}}, {CH_W{rb[1]}}, {CH_W{rb[0]}}};
                end
                else
                begin
                    px = PIX_W'($urandom);
                end
                send_item(CMD_PIXEL, px, got);
            end

            pick = $urandom_range(9);
            if (pick < 6)
            begin
                while (pending != 0) send_item(CMD_DRAIN, PIX_W'($urandom), got);
                repeat ($urandom_range(0, 2)) send_item(CMD_DRAIN, PIX_W'($urandom), got);
            end
            else if (pick < 8)
            begin
                repeat ($urandom_range(0, pending))
                    send_item(CMD_DRAIN, PIX_W'($urandom), got);
            end
        end

        @(negedge clk);
        pix_in_bus.valid = 1'b0;
        while (expected_pixels.size() != 0) @(posedge clk);
        repeat (4 * PIPE_SETTLE) @(posedge clk);

        $display("Sent %0d items and %0d register writes; checked %0d results, %0d frame ends.",
                 transfers, reg_writes, results_checked, frame_ends);
        $display("Frames from 1x1 to 40 wide, oversized registers, drains and mid-frame resizes.");
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
